[hw/rtl/prime_range_enumerator_defines.svh]
// Assertion macros shared by the prime range enumerator RTL.
`ifndef PRIME_RANGE_ENUMERATOR_DEFINES_SVH
`define PRIME_RANGE_ENUMERATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PRE_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PRE_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/pre_pkg.sv]
// Types and constants shared by the prime range enumerator modules.
package pre_pkg;

    localparam int VALUE_WIDTH_DEF = 16;
    localparam int CFG_INDEX_W     = 2;
    localparam int FIRST_DIVISOR   = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_BOUND_ONE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BOUND_TWO = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_TEST,
        ST_DIVIDE,
        ST_EVAL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic start;
        logic test_init;
        logic div_start;
        logic div_step;
        logic next_div;
        logic next_cand;
        logic res_load;
        logic res_found;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic cand_lt_hi;
        logic cand_lt_two;
        logic sq_gt_cand;
        logic div_last;
        logic rem_zero;
        logic out_free;
    } sts_t;

endpackage

[hw/rtl/prime_range_enumerator.sv]
// Top level of the trial-division prime range enumerator.
//
//  channel   direction  handshake            payload
//  s_        in         s_valid / s_ready    s_restart
//  m_        out        m_valid / m_ready    m_prime_value, m_found
//  cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_wdata
//
// One request is taken at a time. Each candidate is divided by trial divisors d
// (2 up to sqrt(candidate)) in the bit-serial remainder unit, stopping at the first
// divisor that divides it; the divisor loop sets the latency.
// Synchronous active-low reset; no clearing pass. cfg_ready is always high.
// The result word is registered, so a new request is taken while it waits on m_ready.
module prime_range_enumerator #(
    parameter int VALUE_WIDTH = pre_pkg::VALUE_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pre_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [VALUE_WIDTH-1:0]          cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_restart,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [VALUE_WIDTH-1:0]          m_prime_value,
    output logic                            m_found
);

    pre_pkg::cmd_t cmd;
    pre_pkg::sts_t sts;

    pre_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    pre_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_restart     (s_restart),
        .cmd           (cmd),
        .sts           (sts),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_prime_value (m_prime_value),
        .m_found       (m_found)
    );

endmodule

[hw/rtl/pre_ctrl.sv]
// Sequencer for the candidate search and trial division loop.
module pre_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  pre_pkg::sts_t sts,
    output pre_pkg::cmd_t cmd
);

    pre_pkg::state_t state_reg;
    pre_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pre_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pre_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = pre_pkg::ST_CHECK;
                end
            end
            pre_pkg::ST_CHECK: begin
                if (!sts.cand_lt_hi) begin
                    state_next = pre_pkg::ST_DONE;
                end else if (!sts.cand_lt_two) begin
                    state_next = pre_pkg::ST_TEST;
                end
            end
            pre_pkg::ST_TEST: begin
                if (sts.sq_gt_cand) begin
                    state_next = pre_pkg::ST_DONE;
                end else begin
                    state_next = pre_pkg::ST_DIVIDE;
                end
            end
            pre_pkg::ST_DIVIDE: begin
                if (sts.div_last) begin
                    state_next = pre_pkg::ST_EVAL;
                end
            end
            pre_pkg::ST_EVAL: begin
                if (sts.rem_zero) begin
                    state_next = pre_pkg::ST_CHECK;
                end else begin
                    state_next = pre_pkg::ST_TEST;
                end
            end
            pre_pkg::ST_DONE: begin
                if (sts.out_free) begin
                    state_next = pre_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pre_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            pre_pkg::ST_IDLE: begin
                s_ready   = 1'b1;
                cmd.start = s_valid;
            end
            pre_pkg::ST_CHECK: begin
                if (!sts.cand_lt_hi) begin
                    cmd.res_load = 1'b1;
                end else if (sts.cand_lt_two) begin
                    cmd.next_cand = 1'b1;
                end else begin
                    cmd.test_init = 1'b1;
                end
            end
            pre_pkg::ST_TEST: begin
                if (sts.sq_gt_cand) begin
                    // no divisor up to the square root: candidate is prime
                    cmd.res_load  = 1'b1;
                    cmd.res_found = 1'b1;
                    cmd.next_cand = 1'b1;
                end else begin
                    cmd.div_start = 1'b1;
                end
            end
            pre_pkg::ST_DIVIDE: begin
                cmd.div_step = 1'b1;
            end
            pre_pkg::ST_EVAL: begin
                if (sts.rem_zero) begin
                    cmd.next_cand = 1'b1;
                end else begin
                    cmd.next_div = 1'b1;
                end
            end
            pre_pkg::ST_DONE: begin
                cmd.out_load = sts.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

[hw/rtl/pre_dp.sv]
// Datapath: bounds, candidate, divisor and square, bit-serial remainder, result word.
`include "prime_range_enumerator_defines.svh"

module pre_dp #(
    parameter int VALUE_WIDTH = pre_pkg::VALUE_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pre_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [VALUE_WIDTH-1:0]          cfg_wdata,
    input  logic                            s_restart,
    input  pre_pkg::cmd_t                   cmd,
    output pre_pkg::sts_t                   sts,
    input  logic                            m_ready,
    output logic                            m_valid,
    output logic [VALUE_WIDTH-1:0]          m_prime_value,
    output logic                            m_found
);

    localparam int W  = VALUE_WIDTH;
    localparam int CW = W + 1;
    localparam int DW = (W + 1) / 2 + 2;
    localparam int SW = 2 * DW;
    localparam int NW = $clog2(W);

    logic [W-1:0]  bound_one_reg;
    logic [W-1:0]  bound_two_reg;
    logic [CW-1:0] cand_reg;
    logic          started_reg;
    logic [DW-1:0] div_reg;
    logic [SW-1:0] sq_reg;
    logic [DW-1:0] rem_reg;
    logic [W-1:0]  dvd_reg;
    logic [NW-1:0] cnt_reg;
    logic [W-1:0]  res_value_reg;
    logic          res_found_reg;
    logic          m_valid_reg;
    logic [W-1:0]  m_value_reg;
    logic          m_found_reg;

    logic [W-1:0]  lo;
    logic [W-1:0]  hi;
    logic [SW-1:0] cand_ext;
    logic [DW:0]   trial;
    logic          trial_ge;
    logic          cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid;

    assign lo = (bound_one_reg < bound_two_reg) ? bound_one_reg : bound_two_reg;
    assign hi = (bound_one_reg < bound_two_reg) ? bound_two_reg : bound_one_reg;

    assign cand_ext = SW'(cand_reg);

    // one restoring division step: shift in the next dividend bit
    assign trial    = {rem_reg, dvd_reg[W-1]};
    assign trial_ge = trial >= (DW + 1)'(div_reg);

    assign sts.cand_lt_hi  = cand_reg < CW'(hi);
    assign sts.cand_lt_two = cand_reg < CW'(pre_pkg::FIRST_DIVISOR);
    assign sts.sq_gt_cand  = sq_reg > cand_ext;
    assign sts.div_last    = cnt_reg == '0;
    assign sts.rem_zero    = rem_reg == '0;
    assign sts.out_free    = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bound_one_reg <= '0;
            bound_two_reg <= '0;
            started_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cmd.start) begin
                started_reg <= 1'b1;
            end
            if (cfg_we && cfg_index == pre_pkg::REG_BOUND_ONE) begin
                bound_one_reg <= cfg_wdata;
                started_reg   <= 1'b0;
            end else if (cfg_we && cfg_index == pre_pkg::REG_BOUND_TWO) begin
                bound_two_reg <= cfg_wdata;
                started_reg   <= 1'b0;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start && (s_restart || !started_reg)) begin
            cand_reg <= CW'(lo) + CW'(1);
        end else if (cmd.next_cand) begin
            cand_reg <= cand_reg + CW'(1);
        end
        if (cmd.test_init) begin
            div_reg <= DW'(pre_pkg::FIRST_DIVISOR);
            sq_reg  <= SW'(pre_pkg::FIRST_DIVISOR * pre_pkg::FIRST_DIVISOR);
        end else if (cmd.next_div) begin
            // (d+1)^2 = d^2 + 2d + 1
            div_reg <= div_reg + DW'(1);
            sq_reg  <= sq_reg + SW'({div_reg, 1'b1});
        end
        if (cmd.div_start) begin
            rem_reg <= '0;
            dvd_reg <= cand_reg[W-1:0];
            cnt_reg <= NW'(W - 1);
        end else if (cmd.div_step) begin
            rem_reg <= trial_ge ? DW'(trial - (DW + 1)'(div_reg)) : DW'(trial);
            dvd_reg <= {dvd_reg[W-2:0], 1'b0};
            cnt_reg <= cnt_reg - NW'(1);
        end
        if (cmd.res_load) begin
            res_value_reg <= cmd.res_found ? cand_reg[W-1:0] : '0;
            res_found_reg <= cmd.res_found;
        end
        if (cmd.out_load) begin
            m_value_reg <= res_value_reg;
            m_found_reg <= res_found_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_prime_value = m_value_reg;
    assign m_found       = m_found_reg;

    `PRE_ASSERT_IMP(a_no_overwrite, aclk, aresetn, cmd.out_load, !m_valid_reg || m_ready,
        "result word overwritten while pending")
    `PRE_ASSERT_IMP(a_prime_in_range, aclk, aresetn, cmd.res_load && cmd.res_found,
        cand_reg < CW'(hi) && cand_reg >= CW'(pre_pkg::FIRST_DIVISOR),
        "reported prime outside the search range")
    `PRE_ASSERT_IMP(a_divisor_valid, aclk, aresetn, cmd.div_step,
        sq_reg <= cand_ext && div_reg >= DW'(pre_pkg::FIRST_DIVISOR),
        "trial divisor beyond square root of candidate")
    `PRE_ASSERT_NXT(a_started, aclk, aresetn, cmd.start && !cfg_we, started_reg,
        "search not marked started after a request")

endmodule

[test/tb_top.sv]
// Testbench for prime_range_enumerator: random bounds and requests checked against a predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VW             = pre_pkg::VALUE_WIDTH_DEF;
    localparam int RANDOM_ITEMS   = 280;
    localparam int CALM_ITEMS     = 40;
    localparam int LONG_HOLD      = 3000;
    localparam int DRAIN_CYCLES   = 50;
    localparam int WATCHDOG_LIMIT = 400000;
    localparam int MAX_PRINTS     = 50;

    typedef struct packed {
        logic [VW-1:0] value;
        logic          found;
    } prime_word_t;

    class prime_tracker;
        logic [VW-1:0] limit_a;
        logic [VW-1:0] limit_b;
        int unsigned   resume_at;
        bit            in_progress;
        prime_word_t   awaited_primes[$];
        int            errors;

        function new();
            limit_a     = '0;
            limit_b     = '0;
            resume_at   = 1;
            in_progress = 1'b0;
            errors      = 0;
        endfunction

        function int pending();
            return awaited_primes.size();
        endfunction

        function void set_bound(logic [pre_pkg::CFG_INDEX_W-1:0] index,
                                logic [VW-1:0] data);
            if (index == pre_pkg::REG_BOUND_ONE) begin
                limit_a     = data;
                in_progress = 1'b0;
            end else if (index == pre_pkg::REG_BOUND_TWO) begin
                limit_b     = data;
                in_progress = 1'b0;
            end
        endfunction

        function bit is_prime(int unsigned c);
            int unsigned d;
            if (c < 2)
                return 1'b0;
            for (d = 2; d * d <= c; d++)
                if (c % d == 0)
                    return 1'b0;
            return 1'b1;
        endfunction

        // Walk forward from the stored candidate to the next prime below the upper bound.
        function void predict_next_prime(bit restart);
            int unsigned lo;
            int unsigned hi;
            int unsigned c;
            prime_word_t want;
            lo = (limit_a < limit_b) ? 32'(limit_a) : 32'(limit_b);
            hi = (limit_a < limit_b) ? 32'(limit_b) : 32'(limit_a);
            if (restart || !in_progress) begin
                resume_at   = lo + 1;
                in_progress = 1'b1;
            end
            want = '0;
            for (c = resume_at; c < hi && !want.found; c++) begin
                if (is_prime(c)) begin
                    want.value = c[VW-1:0];
                    want.found = 1'b1;
                    resume_at  = c + 1;
                end
            end
            // exhausted: park at the upper bound so later requests keep answering none
            if (!want.found && resume_at < hi)
                resume_at = hi;
            awaited_primes.push_back(want);
        endfunction

        task report_mismatch(string what);
            errors++;
            if (errors <= MAX_PRINTS)
                $display("t=%0t mismatch: %s", $time, what);
        endtask

        task check_prime_word(logic [VW-1:0] value, logic found);
            prime_word_t want;
            if (awaited_primes.size() == 0) begin
                report_mismatch($sformatf("unexpected word value=%0d found=%b", value, found));
                return;
            end
            want = awaited_primes.pop_front();
            if (value !== want.value)
                report_mismatch($sformatf("prime_value got %0d want %0d", value, want.value));
            if (found !== want.found)
                report_mismatch($sformatf("found got %b want %b", found, want.found));
        endtask
    endclass

    logic                            aclk          = 1'b0;
    logic                            aresetn       = 1'b0;
    logic                            cfg_valid     = 1'b0;
    logic                            cfg_ready;
    logic [pre_pkg::CFG_INDEX_W-1:0] cfg_index     = pre_pkg::REG_BOUND_ONE;
    logic [VW-1:0]                   cfg_wdata     = '0;
    logic                            s_valid       = 1'b0;
    logic                            s_ready;
    logic                            s_restart     = 1'b0;
    logic                            m_valid;
    logic                            m_ready       = 1'b0;
    logic [VW-1:0]                   m_prime_value;
    logic                            m_found;

    prime_tracker tracker = new();
    bit           calm         = 1'b0;
    int           hold_ticket  = 0;
    int           quiet_cycles = 0;

    prime_range_enumerator #(
        .VALUE_WIDTH(VW)
    ) u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_restart    (s_restart),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_prime_value(m_prime_value),
        .m_found      (m_found)
    );

    always #5 aclk = ~aclk;

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Result side: random stalls, plus one long hold-off on request from the stimulus.
    initial begin : result_sink
        int unsigned stall_left;
        int          hold_served;
        stall_left  = 0;
        hold_served = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                tracker.check_prime_word(m_prime_value, m_found);
            if (hold_ticket != hold_served) begin
                hold_served = hold_ticket;
                stall_left  = LONG_HOLD;
            end else if (stall_left == 0 && !calm && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 18);
            end
            if (stall_left != 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // valid is only dropped ahead of a gap, never lowered and raised in one step
    task automatic request_next_prime(input bit restart);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_restart <= restart;
        do @(posedge aclk); while (!s_ready);
        tracker.predict_next_prime(restart);
    endtask

    task automatic await_all_primes();
        s_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge aclk);
        // let the block fall back to idle after the last word
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_bound(input logic [pre_pkg::CFG_INDEX_W-1:0] index,
                               input logic [VW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= data;
        do @(posedge aclk); while (!cfg_ready);
        tracker.set_bound(index, data);
    endtask

    task automatic program_bounds(input bit wr_one, input bit wr_two,
                                  input logic [VW-1:0] v_one, input logic [VW-1:0] v_two);
        await_all_primes();
        if (wr_one)
            write_bound(pre_pkg::REG_BOUND_ONE, v_one);
        if (wr_two)
            write_bound(pre_pkg::REG_BOUND_TWO, v_two);
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        logic [VW-1:0] a;
        logic [VW-1:0] b;
        logic [VW-1:0] tmp;
        int            mode;
        int            n;
        int            phase;
        int            span;
        int            sent;
        bit            wr_one;
        bit            wr_two;

        do @(posedge aclk); while (!aresetn);

        // both bounds zero out of reset: empty range, first request starts the search
        request_next_prime(1'b0);
        request_next_prime(1'b1);

        // bounds given high first; run past the end, then restart
        program_bounds(1'b1, 1'b1, 10, 2);
        repeat (5) request_next_prime(1'b0);
        request_next_prime(1'b1);

        // rewriting one bound drops the old candidate
        program_bounds(1'b0, 1'b1, 0, 30);
        request_next_prime(1'b0);
        request_next_prime(1'b0);

        // equal, then adjacent bounds
        program_bounds(1'b1, 1'b1, 13, 13);
        request_next_prime(1'b0);
        program_bounds(1'b1, 1'b0, 14, 0);
        request_next_prime(1'b0);

        // 0 and 1 must not come out as primes
        program_bounds(1'b1, 1'b1, 0, 3);
        request_next_prime(1'b1);
        request_next_prime(1'b0);

        program_bounds(1'b1, 1'b1, 65535, 65500);
        repeat (3) request_next_prime(1'b0);
        request_next_prime(1'b1);

        program_bounds(1'b1, 1'b1, 0, 65535);
        request_next_prime(1'b1);
        request_next_prime(1'b0);

        phase = 0;
        sent  = 0;
        while (sent < RANDOM_ITEMS) begin
            mode   = $urandom_range(0, 9);
            wr_one = 1'b1;
            wr_two = 1'b1;
            if ($urandom_range(0, 4) == 0) begin
                if ($urandom_range(0, 1))
                    wr_one = 1'b0;
                else
                    wr_two = 1'b0;
            end
            if (mode < 6) begin
                a = VW'($urandom_range(0, 700));
                b = VW'($urandom_range(0, 700));
                n = $urandom_range(5, 25);
            end else if (mode < 8) begin
                // wide range, but the walk starts low so it stays cheap
                a = VW'($urandom_range(0, 300));
                b = VW'($urandom_range(0, 65535));
                n = $urandom_range(5, 20);
            end else if (mode == 8) begin
                // narrow window anywhere in the value range: slow, so only a few requests
                span = $urandom_range(0, 120);
                a    = VW'($urandom_range(0, 65535 - span));
                b    = VW'(a + span);
                n    = $urandom_range(3, 8);
            end else begin
                a = VW'($urandom_range(0, 40));
                b = VW'(a + $urandom_range(0, 3));
                n = $urandom_range(4, 10);
            end
            if ($urandom_range(0, 1)) begin
                tmp = a;
                a   = b;
                b   = tmp;
            end
            if (phase == 2) begin
                // small range keeps each search short, so the hold-off below backs the block up
                wr_one = 1'b1;
                wr_two = 1'b1;
                a      = '0;
                b      = VW'(200);
            end
            program_bounds(wr_one, wr_two, a, b);
            if (phase == 2) begin
                // sink holds off while requests keep coming, so the input backs up
                n = 12;
                hold_ticket <= hold_ticket + 1;
            end
            calm = (sent >= RANDOM_ITEMS - CALM_ITEMS);
            repeat (n) begin
                request_next_prime($urandom_range(0, 9) == 0);
                sent++;
            end
            phase++;
        end

        await_all_primes();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (tracker.errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
